[src/pcts_pkg.sv]
`default_nettype none
package pcts_pkg;
	localparam int NUM_CONTEXTS_D = 16;
	localparam int NUM_APPS_D = 8;
	localparam int NUM_LEVELS_D = 16;
	localparam int KIND_W = 3;
	localparam int CTX_W = 4;
	localparam int APP_W = 3;
	localparam int LVL_W = 4;
	localparam int ACT_W = 2;

	localparam logic [KIND_W-1:0] K_BIND = 3'd0;
	localparam logic [KIND_W-1:0] K_ACTIVATE = 3'd1;
	localparam logic [KIND_W-1:0] K_REPORT = 3'd2;
	localparam logic [KIND_W-1:0] K_KILL = 3'd3;
	localparam logic [KIND_W-1:0] K_SETPRI = 3'd4;
	localparam logic [KIND_W-1:0] K_DISPATCH = 3'd5;
	localparam logic [KIND_W-1:0] K_FINISH = 3'd6;

	localparam logic [ACT_W-1:0] A_NONE = 2'd0;
	localparam logic [ACT_W-1:0] A_REPORT = 2'd1;
	localparam logic [ACT_W-1:0] A_RUN = 2'd2;
	localparam logic [ACT_W-1:0] A_FINAL = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CTX_W-1:0] context_req;
		logic [APP_W-1:0] application;
		logic [LVL_W-1:0] level;
	} req_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [CTX_W-1:0] chosen_context;
		logic status;
	} rsp_t;

	// queue cell command
	typedef struct packed {
		logic ins;
		logic del_head;
		logic del_match;
		logic sort_step;
	} qcmd_t;
endpackage
`default_nettype wire

[src/pcts_if.sv]
`default_nettype none
interface pcts_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[src/pcts_cell.sv]
`default_nettype none
module pcts_cell
	import pcts_pkg::*;
#(
	parameter int CW = CTX_W,
	parameter int LW = LVL_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire qcmd_t cmd,
	input wire logic odd_phase,
	input wire logic is_odd,
	input wire logic [CW-1:0] ins_ctx,
	input wire logic [LW-1:0] ins_lvl,
	input wire logic [LW-1:0] new_lvl,
	input wire logic lvl_upd,
	input wire logic lvl_hit,
	input wire logic left_valid,
	input wire logic [CW-1:0] left_ctx,
	input wire logic [LW-1:0] left_lvl,
	input wire logic right_valid,
	input wire logic [CW-1:0] right_ctx,
	input wire logic [LW-1:0] right_lvl,
	input wire logic left_pos_ins,
	input wire logic left_del,
	input wire logic self_del,
	output logic valid,
	output logic [CW-1:0] ctx,
	output logic [LW-1:0] lvl
);
	logic valid_q;
	logic [CW-1:0] ctx_q;
	logic [LW-1:0] lvl_q;
	logic pos_ins;
	logic swap_lo, swap_hi;

	assign valid = valid_q;
	assign ctx = ctx_q;
	assign lvl = lvl_q;
	// insertion point: first slot whose level exceeds the new one, or first empty
	assign pos_ins = !valid_q || (lvl_q > ins_lvl);
	// odd-even transposition step; pair lower index = this cell when parity matches
	assign swap_lo = (is_odd == odd_phase) && valid_q && right_valid && (lvl_q > right_lvl);
	assign swap_hi = (is_odd != odd_phase) && valid_q && left_valid && (left_lvl > lvl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (left_pos_ins) valid_q <= left_valid;
			else if (pos_ins) valid_q <= 1'b1;
		end else if (cmd.del_head || cmd.del_match) begin
			if (left_del || self_del) valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_pos_ins) begin
				ctx_q <= left_ctx;
				lvl_q <= left_lvl;
			end else if (pos_ins) begin
				ctx_q <= ins_ctx;
				lvl_q <= ins_lvl;
			end
		end else if (cmd.del_head || cmd.del_match) begin
			if (left_del || self_del) begin
				ctx_q <= right_ctx;
				lvl_q <= right_lvl;
			end
		end else if (cmd.sort_step) begin
			if (swap_lo) begin
				ctx_q <= right_ctx;
				lvl_q <= right_lvl;
			end else if (swap_hi) begin
				ctx_q <= left_ctx;
				lvl_q <= left_lvl;
			end
		end else if (lvl_upd && lvl_hit) begin
			lvl_q <= new_lvl;
		end
	end
endmodule
`default_nettype wire

[src/pcts_queue.sv]
`default_nettype none
module pcts_queue
	import pcts_pkg::*;
#(
	parameter int N = NUM_CONTEXTS_D,
	parameter int CW = CTX_W,
	parameter int LW = LVL_W
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire qcmd_t cmd,
	input wire logic odd_phase,
	input wire logic [CW-1:0] ins_ctx,
	input wire logic [LW-1:0] ins_lvl,
	input wire logic [CW-1:0] del_ctx,
	input wire logic lvl_upd,
	input wire logic [N-1:0] lvl_hit,
	input wire logic [LW-1:0] new_lvl,
	output logic head_valid,
	output logic [CW-1:0] head_ctx,
	output logic [N-1:0] slot_valid,
	output logic [N*CW-1:0] slot_ctx
);
	logic [N-1:0] v;
	logic [N-1:0] pi;
	logic [N-1:0] pf;
	logic [N-1:0] dl;
	logic [N-1:0] hit;
	logic [CW-1:0] c [N];
	logic [LW-1:0] l [N];

	assign head_valid = v[0];
	assign head_ctx = c[0];
	assign slot_valid = v;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic lv, rv, lpi, ldl;
		logic [CW-1:0] lc, rc;
		logic [LW-1:0] ll, rl;
		logic sd;
		assign slot_ctx[i*CW +: CW] = c[i];
		assign pi[i] = !v[i] || (l[i] > ins_lvl);
		assign hit[i] = v[i] && (c[i] == del_ctx);
		assign sd = cmd.del_head ? (i == 0) : hit[i];
		if (i == 0) begin : g_l
			assign lv = 1'b0; assign lc = '0; assign ll = '0;
			assign lpi = 1'b0; assign ldl = 1'b0;
			assign pf[i] = pi[i];
			assign dl[i] = sd;
		end else begin : g_l
			assign lv = v[i-1]; assign lc = c[i-1]; assign ll = l[i-1];
			assign lpi = pf[i-1]; assign ldl = dl[i-1];
			assign pf[i] = pf[i-1] || pi[i];
			assign dl[i] = dl[i-1] || sd;
		end
		if (i == N-1) begin : g_r
			assign rv = 1'b0; assign rc = '0; assign rl = '0;
		end else begin : g_r
			assign rv = v[i+1]; assign rc = c[i+1]; assign rl = l[i+1];
		end
		pcts_cell #(.CW(CW), .LW(LW)) u_cell (
			.clk, .arst_n, .cmd, .odd_phase,
			.is_odd(1'(i % 2)),
			.ins_ctx, .ins_lvl, .new_lvl, .lvl_upd,
			.lvl_hit(lvl_hit[i]),
			.left_valid(lv), .left_ctx(lc), .left_lvl(ll),
			.right_valid(rv), .right_ctx(rc), .right_lvl(rl),
			.left_pos_ins(lpi), .left_del(ldl), .self_del(sd),
			.valid(v[i]), .ctx(c[i]), .lvl(l[i])
		);
	end
endmodule
`default_nettype wire

[src/priority_class_task_scheduler_top.sv]
// A re-sort follows a SETPRI for an application whose level was already set;
// the input stalls during it, and the re-sort is one odd-even step per queue
// cell through the chain of queue cells.
// The input stalls until the held response is taken.
// Reset (arst_n low): all marks, owners, levels and the queue clear at once.
`default_nettype none
module priority_class_task_scheduler_top
	import pcts_pkg::*;
#(
	parameter int NUM_CONTEXTS = NUM_CONTEXTS_D,
	parameter int NUM_APPS = NUM_APPS_D,
	parameter int NUM_LEVELS = NUM_LEVELS_D
) (
	input wire logic clk,
	input wire logic arst_n,
	pcts_if.sink req,
	pcts_if.source rsp
);
	localparam int N = NUM_CONTEXTS;
	localparam int NI = (N > 16) ? 16 : N;
	localparam int AI = (NUM_APPS > 8) ? 8 : NUM_APPS;
	localparam int CIW = (NI > 1) ? $clog2(NI) : 1;
	localparam int AIW = (AI > 1) ? $clog2(AI) : 1;
	localparam int SW = $clog2(N + 2);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	localparam int RP = 0, PR = 1, RN = 2, KL = 3, QU = 4, PD = 5;

	req_t r;
	assign r = req.data;

	logic [1:0] state_q;
	logic [SW-1:0] cnt_q;
	logic odd_q;
	logic [5:0] marks_q [NI];
	logic [APP_W-1:0] owner_q [NI];
	logic [LVL_W-1:0] alvl_q [AI];
	logic [AI-1:0] known_q;
	logic [$clog2(NI+1)-1:0] qcnt_q;
	rsp_t out_q;
	logic out_v_q;

	logic acc;
	assign req.ready = (state_q == ST_IDLE) && !out_v_q;
	assign acc = req.valid && req.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	logic [CTX_W-1:0] cx;
	logic [3:0] cxi;
	logic ctx_ok, app_ok;
	logic [5:0] m;
	assign cx = r.context_req;
	assign ctx_ok = 32'(cx) < NI;
	assign app_ok = 32'(r.application) < AI;
	assign cxi = ctx_ok ? 4'(cx) : 4'd0;
	assign m = marks_q[cxi[CIW-1:0]];

	function automatic logic [LVL_W-1:0] lvl_of_app(input logic [APP_W-1:0] a,
		input logic [LVL_W-1:0] lv [AI]);
		logic [LVL_W-1:0] x;
		x = '0;
		for (int k = 0; k < AI; k++) if (32'(a) == k) x = lv[k];
		return x;
	endfunction

	function automatic logic [NI-1:0] hit_any(input logic [NI-1:0] v,
		input logic [NI*CTX_W-1:0] c, input logic [CTX_W-1:0] t);
		logic [NI-1:0] h;
		for (int k = 0; k < NI; k++) h[k] = v[k] && (c[k*CTX_W +: CTX_W] == t);
		return h;
	endfunction

	logic [LVL_W-1:0] ctx_lvl;
	assign ctx_lvl = lvl_of_app(owner_q[cxi[CIW-1:0]], alvl_q);

	logic pend_any;
	logic [CTX_W-1:0] pend_idx;
	always_comb begin
		pend_any = 1'b0;
		pend_idx = '0;
		for (int k = NI-1; k >= 0; k--) begin
			if (marks_q[k][PD]) begin
				pend_any = 1'b1;
				pend_idx = CTX_W'(k);
			end
		end
	end

	qcmd_t cmd;
	logic head_v;
	logic [CTX_W-1:0] head_c;
	logic [NI-1:0] sv;
	logic [NI*CTX_W-1:0] sc;
	logic [NI-1:0] lhit;
	logic lvl_upd;
	logic [LVL_W-1:0] sat_lvl;
	assign sat_lvl = (32'(r.level) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1) : r.level;

	always_comb begin
		for (int k = 0; k < NI; k++)
			lhit[k] = owner_q[sc[k*CTX_W +: CIW]] == r.application;
	end

	rsp_t nx;
	logic [5:0] nm;
	logic wr_m, do_sort, do_ins, do_delm, do_delh, do_bind;
	logic [3:0] wc;
	always_comb begin
		nx = '{action: A_NONE, chosen_context: cx, status: 1'b0};
		nm = m; wr_m = 1'b0; wc = cxi;
		do_sort = 1'b0; do_ins = 1'b0; do_delm = 1'b0; do_delh = 1'b0; do_bind = 1'b0;
		lvl_upd = 1'b0;
		case (r.kind)
			K_BIND: begin
				if (!ctx_ok || !app_ok || m != 6'd0) nx.status = 1'b1;
				else do_bind = 1'b1;
			end
			K_ACTIVATE, K_REPORT, K_KILL: begin
				if (!ctx_ok || m[KL]) nx.status = 1'b1;
				else begin
					wr_m = 1'b1;
					if (r.kind == K_ACTIVATE) nm[PR] = 1'b1;
					else if (r.kind == K_REPORT) nm[RP] = 1'b1;
					else nm[KL] = 1'b1;
					if (!m[RN]) begin
						if (r.kind == K_REPORT) nm[PD] = 1'b1;
						else if (!m[QU] && 32'(qcnt_q) < NI) begin
							nm[QU] = 1'b1; do_ins = 1'b1;
						end
					end
				end
			end
			K_SETPRI: begin
				if (!app_ok) nx.status = 1'b1;
				else begin
					lvl_upd = 1'b1;
					do_sort = known_q[r.application[AIW-1:0]];
				end
			end
			K_DISPATCH: begin
				nx.chosen_context = '0;
				if (pend_any) begin
					wc = pend_idx; wr_m = 1'b1;
					nm = marks_q[pend_idx[CIW-1:0]];
					nm[PD] = 1'b0; nm[RP] = 1'b0; nm[RN] = 1'b1;
					nx.action = A_REPORT; nx.chosen_context = pend_idx;
				end else if (head_v) begin
					wc = head_c; wr_m = 1'b1; do_delh = 1'b1;
					nm = marks_q[head_c[CIW-1:0]];
					nm[QU] = 1'b0; nm[PR] = 1'b0; nm[RN] = 1'b1;
					nx.action = A_RUN; nx.chosen_context = head_c;
				end
			end
			K_FINISH: begin
				if (!ctx_ok || !m[RN]) nx.status = 1'b1;
				else begin
					wr_m = 1'b1; nm[RN] = 1'b0;
					if (m[RP]) nm[PD] = 1'b1;
					else if (m[PR]) begin
						if (!m[QU] && 32'(qcnt_q) < NI) begin
							nm[QU] = 1'b1; do_ins = 1'b1;
						end
					end else if (m[KL]) begin
						nm = '0; do_delm = 1'b1; nx.action = A_FINAL;
					end
				end
			end
			default: nx.status = 1'b1;
		endcase
	end

	always_comb begin
		cmd = '0;
		if (acc) begin
			cmd.ins = do_ins;
			cmd.del_head = do_delh;
			cmd.del_match = do_delm;
		end else if (state_q == ST_SORT) begin
			cmd.sort_step = 1'b1;
		end
	end

	pcts_queue #(.N(NI), .CW(CTX_W), .LW(LVL_W)) u_queue (
		.clk, .arst_n, .cmd, .odd_phase(odd_q),
		.ins_ctx(cx), .ins_lvl(ctx_lvl), .del_ctx(cx),
		.lvl_upd(acc && lvl_upd), .lvl_hit(lhit), .new_lvl(sat_lvl),
		.head_valid(head_v), .head_ctx(head_c),
		.slot_valid(sv), .slot_ctx(sc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			odd_q <= 1'b0;
			out_v_q <= 1'b0;
			known_q <= '0;
			qcnt_q <= '0;
			for (int k = 0; k < NI; k++) begin
				marks_q[k] <= '0;
				owner_q[k] <= '0;
			end
			for (int k = 0; k < AI; k++) alvl_q[k] <= '0;
		end else begin
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						out_q <= nx;
						if (wr_m) marks_q[wc[CIW-1:0]] <= nm;
						if (do_bind) owner_q[cxi[CIW-1:0]] <= r.application;
						if (lvl_upd) begin
							alvl_q[r.application[AIW-1:0]] <= sat_lvl;
							known_q[r.application[AIW-1:0]] <= 1'b1;
						end
						if (do_ins) qcnt_q <= qcnt_q + 1'b1;
						if ((do_delh && head_v) || (do_delm && |(sv & hit_any(sv, sc, cx))))
							qcnt_q <= qcnt_q - 1'b1;
						if (do_sort) begin
							state_q <= ST_SORT;
							cnt_q <= '0;
							odd_q <= 1'b0;
						end else begin
							out_v_q <= 1'b1;
						end
					end
				end
				ST_SORT: begin
					odd_q <= !odd_q;
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == NI-1) begin
						state_q <= ST_IDLE;
						out_v_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_sort_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> !req.ready)
		else $error("request taken during re-sort");
	a_qcnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(qcnt_q) == $countones(sv))
		else $error("queue count mismatch");
	a_rsp_once: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("new request before response taken");
endmodule
`default_nettype wire

[dv/tb_priority_class_task_scheduler_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_priority_class_task_scheduler_top;
	import pcts_pkg::*;

	localparam int NCTX = NUM_CONTEXTS_D;
	localparam int NAPP = NUM_APPS_D;
	localparam int NLVL = NUM_LEVELS_D;
	localparam int TOTAL_RANDOM = 1900;

	localparam logic [5:0] M_REPORT = 6'd1;
	localparam logic [5:0] M_PROCESS = 6'd2;
	localparam logic [5:0] M_RUNNING = 6'd4;
	localparam logic [5:0] M_KILLED = 6'd8;
	localparam logic [5:0] M_QUEUED = 6'd16;
	localparam logic [5:0] M_PENDING = 6'd32;
	localparam logic [KIND_W-1:0] K_ILLEGAL = 3'd7;

	typedef struct {
		req_t r;
		logic known;
		rsp_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	pcts_if #(.W($bits(req_t))) req_ch ();
	pcts_if #(.W($bits(rsp_t))) rsp_ch ();

	priority_class_task_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	logic [5:0] marks [NCTX];
	logic [APP_W-1:0] owner [NCTX];
	logic [LVL_W-1:0] app_lvl [NAPP];
	logic app_known [NAPP];
	logic [CTX_W-1:0] run_q [$];

	rsp_t pending_rsp [$];
	int errors;
	int send_idle;
	int recv_idle;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#50ms;
		$display("FAIL priority_class_task_scheduler_top");
		$finish;
	end

	function automatic logic [LVL_W-1:0] ctx_level(logic [CTX_W-1:0] c);
		return app_lvl[owner[c]];
	endfunction

	function automatic void enqueue_ctx(logic [CTX_W-1:0] c);
		int pos;
		if (marks[c] & M_QUEUED)
			return;
		if (run_q.size() >= NCTX)
			return;
		marks[c] |= M_QUEUED;
		pos = 0;
		while (pos < run_q.size() && ctx_level(run_q[pos]) <= ctx_level(c))
			pos++;
		run_q.insert(pos, c);
	endfunction

	function automatic void resort_queue();
		logic [CTX_W-1:0] sorted [$];
		for (int l = 0; l < NLVL; l++)
			foreach (run_q[i])
				if (ctx_level(run_q[i]) == l)
					sorted.insert(sorted.size(), run_q[i]);
		run_q = sorted;
	endfunction

	function automatic rsp_t schedule(req_t r);
		rsp_t o;
		logic [LVL_W-1:0] lv;
		logic had;
		logic [CTX_W-1:0] c;
		o.action = A_NONE;
		o.chosen_context = r.context_req;
		o.status = 1'b0;
		c = r.context_req;
		case (r.kind)
			K_BIND: begin
				if (marks[c] != 0)
					o.status = 1'b1;
				else
					owner[c] = r.application;
			end
			K_ACTIVATE, K_REPORT, K_KILL: begin
				if (marks[c] & M_KILLED) begin
					o.status = 1'b1;
				end else begin
					if (r.kind == K_ACTIVATE)
						marks[c] |= M_PROCESS;
					else if (r.kind == K_REPORT)
						marks[c] |= M_REPORT;
					else
						marks[c] |= M_KILLED;
					if (!(marks[c] & M_RUNNING)) begin
						if (r.kind == K_REPORT)
							marks[c] |= M_PENDING;
						else
							enqueue_ctx(c);
					end
				end
			end
			K_SETPRI: begin
				had = app_known[r.application];
				lv = r.level;
				app_lvl[r.application] = lv;
				app_known[r.application] = 1'b1;
				if (had)
					resort_queue();
			end
			K_DISPATCH: begin
				o.chosen_context = '0;
				for (int i = 0; i < NCTX; i++) begin
					if (o.action == A_NONE && (marks[i] & M_PENDING)) begin
						marks[i] = (marks[i] & ~(M_PENDING | M_REPORT)) | M_RUNNING;
						o.action = A_REPORT;
						o.chosen_context = CTX_W'(i);
					end
				end
				if (o.action == A_NONE && run_q.size() > 0) begin
					c = run_q[0];
					run_q.delete(0);
					marks[c] = (marks[c] & ~(M_QUEUED | M_PROCESS)) | M_RUNNING;
					o.action = A_RUN;
					o.chosen_context = c;
				end
			end
			K_FINISH: begin
				if (!(marks[c] & M_RUNNING)) begin
					o.status = 1'b1;
				end else begin
					marks[c] &= ~M_RUNNING;
					if (marks[c] & M_REPORT) begin
						marks[c] |= M_PENDING;
					end else if (marks[c] & M_PROCESS) begin
						enqueue_ctx(c);
					end else if (marks[c] & M_KILLED) begin
						foreach (run_q[i])
							if (run_q[i] == c) begin
								run_q.delete(i);
								break;
							end
						marks[c] = '0;
						o.action = A_FINAL;
					end
				end
			end
			default: o.status = 1'b1;
		endcase
		return o;
	endfunction

	function automatic req_t mk_req(logic [KIND_W-1:0] k, logic [CTX_W-1:0] c,
			logic [APP_W-1:0] a, logic [LVL_W-1:0] l);
		req_t r;
		r.kind = k;
		r.context_req = c;
		r.application = a;
		r.level = l;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(logic [ACT_W-1:0] a, logic [CTX_W-1:0] c, logic s);
		rsp_t o;
		o.action = a;
		o.chosen_context = c;
		o.status = s;
		return o;
	endfunction

	task automatic send_request(req_t r, logic known, rsp_t want);
		rsp_t p;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.data <= r;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		p = schedule(r);
		if (known && p != want) begin
			$error("directed row predictor disagrees: %h vs %h", want, p);
			errors++;
		end
		pending_rsp.insert(pending_rsp.size(), p);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response %h", got);
				errors++;
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				if (got.action !== want.action) begin
					$error("action expected %0d actual %0d", want.action, got.action);
					errors++;
				end
				if (got.chosen_context !== want.chosen_context) begin
					$error("chosen_context expected %0d actual %0d",
						want.chosen_context, got.chosen_context);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
	end

	function automatic req_t random_request(int phase_mix);
		req_t r;
		int pick;
		r.context_req = CTX_W'($urandom_range(NCTX - 1));
		r.application = APP_W'($urandom_range(NAPP - 1));
		r.level = LVL_W'($urandom_range(NLVL - 1));
		if (phase_mix == 0)
			r.context_req = CTX_W'($urandom_range(5));
		pick = $urandom_range(99);
		if (pick < 8)
			r.kind = K_BIND;
		else if (pick < 28)
			r.kind = K_ACTIVATE;
		else if (pick < 36)
			r.kind = K_REPORT;
		else if (pick < 42)
			r.kind = K_KILL;
		else if (pick < 50)
			r.kind = K_SETPRI;
		else if (pick < 75)
			r.kind = K_DISPATCH;
		else if (pick < 98)
			r.kind = K_FINISH;
		else
			r.kind = K_ILLEGAL;
		return r;
	endfunction

	stim_row_t rows [$];

	initial begin
		int wait_cycles;
		errors = 0;
		send_idle = 17;
		recv_idle = 48;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		for (int i = 0; i < NCTX; i++) begin
			marks[i] = '0;
			owner[i] = '0;
		end
		for (int i = 0; i < NAPP; i++) begin
			app_lvl[i] = '0;
			app_known[i] = 1'b0;
		end
		rows = '{
			'{mk_req(K_DISPATCH, 4'd9, 3'd0, 4'd0), 1, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_FINISH, 4'd3, 3'd0, 4'd0), 1, mk_rsp(A_NONE, 4'd3, 1)},
			'{mk_req(K_ILLEGAL, 4'd15, 3'd7, 4'd15), 1, mk_rsp(A_NONE, 4'd15, 1)},
			'{mk_req(K_BIND, 4'd15, 3'd7, 4'd0), 1, mk_rsp(A_NONE, 4'd15, 0)},
			'{mk_req(K_BIND, 4'd0, 3'd1, 4'd0), 1, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_BIND, 4'd5, 3'd2, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_SETPRI, 4'd0, 3'd7, 4'd15), 1, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_ACTIVATE, 4'd15, 3'd0, 4'd0), 1, mk_rsp(A_NONE, 4'd15, 0)},
			'{mk_req(K_ACTIVATE, 4'd0, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_ACTIVATE, 4'd5, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_BIND, 4'd0, 3'd3, 4'd0), 1, mk_rsp(A_NONE, 4'd0, 1)},
			'{mk_req(K_SETPRI, 4'd0, 3'd1, 4'd9), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_SETPRI, 4'd0, 3'd1, 4'd12), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_REPORT, 4'd7, 3'd0, 4'd0), 1, mk_rsp(A_NONE, 4'd7, 0)},
			'{mk_req(K_DISPATCH, 4'd0, 3'd0, 4'd0), 1, mk_rsp(A_REPORT, 4'd7, 0)},
			'{mk_req(K_DISPATCH, 4'd0, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_DISPATCH, 4'd0, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_ACTIVATE, 4'd5, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_DISPATCH, 4'd0, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_KILL, 4'd15, 3'd0, 4'd0), 1, mk_rsp(A_NONE, 4'd15, 0)},
			'{mk_req(K_KILL, 4'd15, 3'd0, 4'd0), 1, mk_rsp(A_NONE, 4'd15, 1)},
			'{mk_req(K_FINISH, 4'd15, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_FINISH, 4'd7, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)},
			'{mk_req(K_FINISH, 4'd5, 3'd0, 4'd0), 0, mk_rsp(A_NONE, 4'd0, 0)}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i])
			send_request(rows[i].r, rows[i].known, rows[i].want);
		for (int n = 0; n < TOTAL_RANDOM; n++) begin
			if (n == TOTAL_RANDOM / 3) begin
				send_idle = 48;
				recv_idle = 17;
			end else if (n == 2 * TOTAL_RANDOM / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_request(random_request(n % 2), 1'b0, '0);
		end
		req_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (pending_rsp.size() > 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (NCTX + 4) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("PASS priority_class_task_scheduler_top");
		else
			$display("FAIL priority_class_task_scheduler_top");
		$finish;
	end
endmodule
`default_nettype wire
